// File: src/mrm_pkg.sv
// ----------------------------------------------------------------------------
// mrm_pkg: shared types and constants of the modem response matcher
// commands, result codes, register indexes and reset values
// ----------------------------------------------------------------------------
package mrm_pkg;

	// default sizing
	localparam int BUFFER_BYTES_DEF      = 128;
	localparam int MAX_PATTERN_BYTES_DEF = 8;

	// register and field widths
	localparam int PATTERN_W = 64;
	localparam int LENGTH_W  = 4;
	localparam int TIMER_W   = 32;
	localparam int CMD_W     = 2;
	localparam int BYTE_W    = 8;
	localparam int STATUS_W  = 2;
	localparam int ADDR_W    = 2;

	// reset values of the configuration registers ("\r\nOK", 4 bytes, 1000 ticks)
	localparam logic [PATTERN_W-1:0] PATTERN_RST = 64'h0000_0000_0D0A_4F4B;
	localparam logic [LENGTH_W-1:0]  LENGTH_RST  = 4'd4;
	localparam logic [TIMER_W-1:0]   TIMEOUT_RST = 32'd1000;

	// the text ERROR, last byte lowest
	localparam int                     ERROR_BYTES = 5;
	localparam logic [8*ERROR_BYTES-1:0] ERROR_TEXT = 40'h45_52_52_4F_52;

	typedef enum logic [CMD_W-1:0] {
		CMD_START = 2'd0,
		CMD_BYTE  = 2'd1,
		CMD_TICK  = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_FOUND   = 2'd0,
		ST_ERROR   = 2'd1,
		ST_FULL    = 2'd2,
		ST_TIMEOUT = 2'd3
	} status_t;

	typedef enum logic [ADDR_W-1:0] {
		REG_PATTERN = 2'd0,
		REG_LENGTH  = 2'd1,
		REG_TIMEOUT = 2'd2
	} reg_idx_t;

	// outcome of checking the history after a received byte
	typedef struct packed {
		logic found;
		logic error_seen;
		logic full;
	} verdict_t;

endpackage

// File: src/mrm_if.sv
// ----------------------------------------------------------------------------
// mrm_if: channel interfaces of the modem response matcher
// valid/ready request channels for items, results and register writes
// ----------------------------------------------------------------------------
interface mrm_item_if import mrm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [BYTE_W-1:0] data_byte;

	modport source (output valid, output command, output data_byte, input ready);
	modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface mrm_result_if import mrm_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;

	modport source (output valid, output status, input ready);
	modport sink   (input valid, input status, output ready);
endinterface

interface mrm_cfg_if import mrm_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [ADDR_W-1:0]    addr;
	logic [PATTERN_W-1:0] wdata;

	modport source (output valid, output addr, output wdata, input ready);
	modport sink   (input valid, input addr, input wdata, output ready);
endinterface

// File: src/mrm_verdict.sv
// ----------------------------------------------------------------------------
// mrm_verdict: history compare of the modem response matcher
// checks the byte history for the pattern, for ERROR and for a full buffer
// ----------------------------------------------------------------------------
module mrm_verdict import mrm_pkg::*; #(
	parameter int BUFFER_BYTES      = BUFFER_BYTES_DEF,
	parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF
) (
	input  logic [8*MAX_PATTERN_BYTES-1:0] history,
	input  logic [$clog2(BUFFER_BYTES)-1:0] count,
	input  logic [PATTERN_W-1:0]            pattern,
	input  logic [LENGTH_W-1:0]             pattern_length,
	output verdict_t                        verdict
);

	localparam int CNT_W = $clog2(BUFFER_BYTES);
	localparam int CMP_W = CNT_W + LENGTH_W;

	logic [LENGTH_W-1:0]          len_sat;
	logic [MAX_PATTERN_BYTES-1:0] byte_ok;

	// lengths beyond the history saturate
	assign len_sat = (pattern_length > LENGTH_W'(MAX_PATTERN_BYTES)) ?
		LENGTH_W'(MAX_PATTERN_BYTES) : pattern_length;

	// bytes past the pattern length always pass
	always_comb begin
		for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
			byte_ok[i] = (history[8*i +: 8] == pattern[8*i +: 8]) ||
				(LENGTH_W'(i) >= len_sat);
		end
	end

	assign verdict.found = (&byte_ok) && (CMP_W'(count) >= CMP_W'(len_sat));
	assign verdict.error_seen = (history[8*ERROR_BYTES-1:0] == ERROR_TEXT) &&
		(CMP_W'(count) >= CMP_W'(ERROR_BYTES));
	assign verdict.full = (count == CNT_W'(BUFFER_BYTES - 1));

endmodule

// File: src/modem_response_matcher_core.sv
// ----------------------------------------------------------------------------
// modem_response_matcher_core: modem reply matcher with timeout
// Watches received modem bytes for an expected reply. A start request clears
// the byte history, byte count and tick timer and arms the matcher; while
// armed, every byte request is shifted into the history and checked in order
// for the configured pattern (found), the text ERROR (error) and a count of
// BUFFER_BYTES-1 (buffer full); tick requests advance a saturating timer and
// report timeout once the elapsed ticks exceed timeout_ticks. Each verdict
// disarms the matcher; while disarmed, bytes and ticks are dropped silently.
// Throughput is one request per clock while the result register is free; a
// request is taken into an input register, evaluated and folded into the
// matcher state once the result register is free, and its result (if any)
// is loaded into the result register at the same edge. The state update
// loop (history, count, timer, armed) sets that rate. Register
// writes are taken at any time and must only be issued while idle.
// ----------------------------------------------------------------------------
module modem_response_matcher_core import mrm_pkg::*; #(
	parameter int BUFFER_BYTES      = BUFFER_BYTES_DEF,
	parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	mrm_item_if.sink     item,
	mrm_result_if.source result,
	mrm_cfg_if.sink      cfg
);

	localparam int CNT_W  = $clog2(BUFFER_BYTES);
	localparam int HIST_W = 8 * MAX_PATTERN_BYTES;

	// configuration registers
	logic [PATTERN_W-1:0] match_pattern_q;
	logic [LENGTH_W-1:0]  pattern_length_q;
	logic [TIMER_W-1:0]   timeout_ticks_q;

	// input register
	logic              valid_s1;
	logic [CMD_W-1:0]  command_s1;
	logic [BYTE_W-1:0] data_byte_s1;

	// matcher state
	logic [HIST_W-1:0]  history_q;
	logic [CNT_W-1:0]   byte_count_q;
	logic [TIMER_W-1:0] elapsed_q;
	logic               armed_q;

	// result register
	logic          out_valid_q;
	status_t       status_q;

	// next state and verdict
	logic [HIST_W-1:0]  history_d;
	logic [CNT_W-1:0]   byte_count_d;
	logic [TIMER_W-1:0] elapsed_d;
	logic               armed_d;
	logic               emit;
	status_t            status_d;

	logic [HIST_W-1:0]  hist_shift;
	logic [CNT_W-1:0]   count_inc;
	logic [TIMER_W-1:0] elapsed_inc;
	verdict_t           verdict;

	logic out_free;
	logic fire;

	// the result register frees up when empty or taken this cycle
	assign out_free   = !out_valid_q || result.ready;
	assign fire       = valid_s1 && out_free;
	assign item.ready = !valid_s1 || out_free;

	assign result.valid  = out_valid_q;
	assign result.status = status_q;

	assign cfg.ready = 1'b1;

	// ------------------------------------------------------------------
	// register writes
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_pattern_q  <= PATTERN_RST;
			pattern_length_q <= LENGTH_RST;
			timeout_ticks_q  <= TIMEOUT_RST;
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.addr))
				REG_PATTERN: match_pattern_q  <= cfg.wdata;
				REG_LENGTH:  pattern_length_q <= cfg.wdata[LENGTH_W-1:0];
				REG_TIMEOUT: timeout_ticks_q  <= cfg.wdata[TIMER_W-1:0];
				default: ; // writes past the register list are dropped
			endcase
		end
	end

	// ------------------------------------------------------------------
	// input register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			command_s1   <= item.command;
			data_byte_s1 <= item.data_byte;
		end
	end

	// ------------------------------------------------------------------
	// evaluation
	// ------------------------------------------------------------------
	// newest byte enters at the bottom of the history
	assign hist_shift  = {history_q[HIST_W-BYTE_W-1:0], data_byte_s1};
	assign count_inc   = byte_count_q + CNT_W'(1);
	// timer sticks at all ones
	assign elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + TIMER_W'(1);

	mrm_verdict #(
		.BUFFER_BYTES      (BUFFER_BYTES),
		.MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
	) u_verdict (
		.history        (hist_shift),
		.count          (count_inc),
		.pattern        (match_pattern_q),
		.pattern_length (pattern_length_q),
		.verdict        (verdict)
	);

	always_comb begin
		history_d    = history_q;
		byte_count_d = byte_count_q;
		elapsed_d    = elapsed_q;
		armed_d      = armed_q;
		emit         = 1'b0;
		status_d     = ST_FOUND;
		case (cmd_t'(command_s1))
			CMD_START: begin
				// clear and (re)arm, also while armed
				history_d    = '0;
				byte_count_d = '0;
				elapsed_d    = '0;
				armed_d      = 1'b1;
			end
			CMD_BYTE: begin
				if (armed_q) begin
					history_d    = hist_shift;
					byte_count_d = count_inc;
					// priority: pattern, then ERROR, then full buffer
					if (verdict.found) begin
						emit     = 1'b1;
						status_d = ST_FOUND;
					end else if (verdict.error_seen) begin
						emit     = 1'b1;
						status_d = ST_ERROR;
					end else if (verdict.full) begin
						emit     = 1'b1;
						status_d = ST_FULL;
					end
					if (emit) begin
						armed_d = 1'b0;
					end
				end
			end
			CMD_TICK: begin
				if (armed_q) begin
					elapsed_d = elapsed_inc;
					if (elapsed_inc > timeout_ticks_q) begin
						emit     = 1'b1;
						status_d = ST_TIMEOUT;
						armed_d  = 1'b0;
					end
				end
			end
			default: ; // unused command, ignored
		endcase
	end

	// ------------------------------------------------------------------
	// matcher state
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			history_q    <= '0;
			byte_count_q <= '0;
			elapsed_q    <= '0;
			armed_q      <= 1'b0;
		end else if (fire) begin
			history_q    <= history_d;
			byte_count_q <= byte_count_d;
			elapsed_q    <= elapsed_d;
			armed_q      <= armed_d;
		end
	end

	// ------------------------------------------------------------------
	// result register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			status_q <= status_d;
		end
	end

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	// a new result only follows a request evaluated in the cycle before
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1))
		else $error("result appeared without a request in the input register");

	// the matcher disarms before the count can pass the buffer limit
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		byte_count_q <= CNT_W'(BUFFER_BYTES - 1))
		else $error("byte count beyond buffer limit");

	// every verdict leaves the matcher disarmed
	a_verdict_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && emit) |=> !armed_q)
		else $error("matcher still armed after a verdict");

	// a start request always leaves a cleared, armed matcher
	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && command_s1 == CMD_START) |=>
		(armed_q && byte_count_q == '0 && elapsed_q == '0))
		else $error("start request did not clear and arm");

endmodule
